// File: rtl/sskt_pkg.sv
// shared types and constants for the sorted sixteen-entry key table
package sskt_pkg;

    localparam int KEY_WIDTH     = 8;
    localparam int COMMAND_WIDTH = 2;
    localparam int STATUS_WIDTH  = 2;
    localparam int FIELD_WIDTH   = 64;
    localparam int COUNT_WIDTH   = 5;

    localparam logic [COUNT_WIDTH-1:0] SHRINK_RESET = 5'd4;

    typedef enum logic [COMMAND_WIDTH-1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CHANGE = 2'd3
    } command_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_SHRINK  = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    // per-cell flags seen by the neighbors
    typedef struct packed {
        logic                 occupied;
        logic                 greater;
        logic                 equal;
        logic                 first;
        logic [KEY_WIDTH-1:0] key;
    } cell_flags_t;

    // command broadcast to every cell
    typedef struct packed {
        logic                 ins_en;
        logic                 rem_en;
        logic                 chg_en;
        logic [KEY_WIDTH-1:0] key;
    } cell_ctrl_t;

endpackage

// File: rtl/sskt_if.sv
// request and response channel interfaces
interface sskt_req_if
    import sskt_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [COMMAND_WIDTH-1:0] command;
    logic [KEY_WIDTH-1:0]     key;
    logic [FIELD_WIDTH-1:0]   child_value;

    modport source (output valid, output command, output key, output child_value, input ready);
    modport sink   (input valid, input command, input key, input child_value, output ready);
endinterface

interface sskt_rsp_if
    import sskt_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [STATUS_WIDTH-1:0] status;
    logic [FIELD_WIDTH-1:0]  found_child;
    logic [COUNT_WIDTH-1:0]  entries_now;

    modport source (output valid, output status, output found_child, output entries_now,
                    input ready);
    modport sink   (input valid, input status, input found_child, input entries_now,
                    output ready);
endinterface

// File: rtl/sorted_sixteen_entry_key_table.sv
// top level: row of table cells, entry count, threshold and response register
//
// Sorted key table with up to CAPACITY byte keys, each paired with a child
// value. Every command (insert, lookup, remove, change child) gets a single
// response beat that is registered and offered the next cycle; a new command
// is accepted in the same cycle the previous response is taken, so while
// responses are taken the sustained rate is one command per clock, set by the
// row of cells: every cell compares its key with the command key and shifts
// from a neighbor in the same cycle. Equal keys are kept adjacent, so lookup,
// remove and change act on the lowest matching slot. The shrink threshold
// register (reset 4) is written via cfg_wen/cfg_wdata by the user only while
// the table is idle (unenforced); remove flags shrink when the count equals it.
module sorted_sixteen_entry_key_table
    import sskt_pkg::*;
#(
    parameter int CAPACITY    = 16,
    parameter int CHILD_WIDTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wen,
    input  logic [COUNT_WIDTH-1:0] cfg_wdata,
    sskt_req_if.sink               request,
    sskt_rsp_if.source             response
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > COUNT_WIDTH) ? CW : COUNT_WIDTH;

    logic [CW-1:0]           count_reg, count_next;
    logic [COUNT_WIDTH-1:0]  threshold_reg;
    logic                    rsp_valid_reg;
    status_t                 status_reg, status_next;
    logic [FIELD_WIDTH-1:0]  found_reg, found_next;
    logic [COUNT_WIDTH-1:0]  entries_reg;

    logic                    accept;
    command_t                command;
    logic [CHILD_WIDTH-1:0]  new_child;
    logic                    full, at_threshold, any_match;
    cell_ctrl_t              ctrl;

    cell_flags_t             flags  [CAPACITY];
    logic [CHILD_WIDTH-1:0]  childs [CAPACITY];
    logic [CAPACITY-1:0]     first_vec;
    logic [CHILD_WIDTH-1:0]  found_child;

    // handshake
    assign accept        = request.valid && request.ready;
    assign request.ready = !rsp_valid_reg || response.ready;

    assign command   = command_t'(request.command);
    assign new_child = request.child_value[CHILD_WIDTH-1:0];

    // command qualification
    assign full         = count_reg == CW'(CAPACITY);
    assign at_threshold = CMPW'(count_reg) == CMPW'(threshold_reg);
    assign any_match    = |first_vec;

    always_comb
    begin
        ctrl.key    = request.key;
        ctrl.ins_en = accept && (command == CMD_INSERT) && !full;
        ctrl.rem_en = accept && (command == CMD_REMOVE) && !at_threshold && any_match;
        ctrl.chg_en = accept && (command == CMD_CHANGE) && any_match;
    end

    // row of cells
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            cell_flags_t            pf, nf;
            logic [CHILD_WIDTH-1:0] pc, nc;
            if (g == 0)
            begin : g_head
                assign pf = '{occupied: 1'b1, greater: 1'b0, equal: 1'b0,
                              first: 1'b0, key: '0};
                assign pc = '0;
            end
            else
            begin : g_mid
                assign pf = flags[g-1];
                assign pc = childs[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_tail
                assign nf = '0;
                assign nc = '0;
            end
            else
            begin : g_body
                assign nf = flags[g+1];
                assign nc = childs[g+1];
            end

            sskt_cell #(
                .CHILD_WIDTH (CHILD_WIDTH)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (count_reg > CW'(g)),
                .new_child  (new_child),
                .prev_flags (pf),
                .prev_child (pc),
                .next_flags (nf),
                .next_child (nc),
                .flags      (flags[g]),
                .child      (childs[g])
            );
            assign first_vec[g] = flags[g].first;
        end
    endgenerate

    // child of the first match, at most one cell hits
    always_comb
    begin
        found_child = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            found_child = found_child | (childs[i] & {CHILD_WIDTH{first_vec[i]}});
        end
    end

    // status, found child and count update
    always_comb
    begin
        status_next = ST_OK;
        found_next  = '0;
        count_next  = count_reg;
        case (command)
            CMD_INSERT:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                    count_next = count_reg + 1'b1;
            end
            CMD_LOOKUP:
            begin
                if (any_match)
                    found_next = FIELD_WIDTH'(found_child);
                else
                    status_next = ST_MISSING;
            end
            CMD_REMOVE:
            begin
                if (at_threshold)
                    status_next = ST_SHRINK;
                else if (any_match)
                    count_next = count_reg - 1'b1;
                else
                    status_next = ST_MISSING;
            end
            CMD_CHANGE:
            begin
                if (!any_match)
                    status_next = ST_MISSING;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            threshold_reg <= SHRINK_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
                threshold_reg <= cfg_wdata;
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            found_reg   <= found_next;
            entries_reg <= COUNT_WIDTH'(count_next);
        end
    end

    assign response.valid       = rsp_valid_reg;
    assign response.status      = status_reg;
    assign response.found_child = found_reg;
    assign response.entries_now = entries_reg;

endmodule

// File: rtl/sskt_cell.sv
// one slot of the sorted table: key, child and the local shift decision
module sskt_cell
    import sskt_pkg::*;
#(
    parameter int CHILD_WIDTH = 64
) (
    input  logic                   clk,
    input  cell_ctrl_t             ctrl,
    input  logic                   occupied,
    input  logic [CHILD_WIDTH-1:0] new_child,
    input  cell_flags_t            prev_flags,
    input  logic [CHILD_WIDTH-1:0] prev_child,
    input  cell_flags_t            next_flags,
    input  logic [CHILD_WIDTH-1:0] next_child,
    output cell_flags_t            flags,
    output logic [CHILD_WIDTH-1:0] child
);

    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    logic [CHILD_WIDTH-1:0] child_reg, child_next;
    logic                   greater, equal, first;
    logic                   ins_here, ins_shift, rem_shift, chg_here;

    // local compares; equal keys sit together, so the first match is local
    assign greater = occupied && (key_reg > ctrl.key);
    assign equal   = occupied && (key_reg == ctrl.key);
    assign first   = equal && !prev_flags.equal;

    assign flags = '{occupied: occupied, greater: greater, equal: equal,
                     first: first, key: key_reg};
    assign child = child_reg;

    // insert lands after the last key not above it; higher keys move up
    assign ins_here  = ctrl.ins_en && prev_flags.occupied && !prev_flags.greater
                       && (greater || !occupied);
    assign ins_shift = ctrl.ins_en && prev_flags.greater;
    // remove pulls everything from the first match upward down by one
    assign rem_shift = ctrl.rem_en && (greater || equal);
    assign chg_here  = ctrl.chg_en && first;

    // next slot contents
    always_comb
    begin
        key_next   = key_reg;
        child_next = child_reg;
        if (ins_here)
        begin
            key_next   = ctrl.key;
            child_next = new_child;
        end
        else if (ins_shift)
        begin
            key_next   = prev_flags.key;
            child_next = prev_child;
        end
        else if (rem_shift)
        begin
            key_next   = next_flags.key;
            child_next = next_child;
        end
        else if (chg_here)
        begin
            child_next = new_child;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        child_reg <= child_next;
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for the sorted sixteen-entry key table: directed table, then random phases
module tb_top
    import sskt_pkg::*;
();

    localparam int TABLE_DEPTH = 16;

    typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

    typedef struct packed {
        status_t                status;
        logic [FIELD_WIDTH-1:0] found_child;
        logic [COUNT_WIDTH-1:0] entries_now;
    } table_reply_t;

    // one row of the directed table; a threshold row carries its value in key
    typedef struct packed {
        row_kind_t              kind;
        command_t               command;
        logic [KEY_WIDTH-1:0]   key;
        logic [FIELD_WIDTH-1:0] child_value;
        logic [4:0]             reps;
        logic                   typed;
        table_reply_t           want;
    } script_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wen;
    logic [COUNT_WIDTH-1:0] cfg_wdata;

    sskt_req_if req_ch ();
    sskt_rsp_if rsp_ch ();

    sorted_sixteen_entry_key_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata),
        .request  (req_ch),
        .response (rsp_ch)
    );

    // shadow copy of the table contents and the threshold register
    logic [KEY_WIDTH-1:0]   key_mirror [TABLE_DEPTH];
    logic [FIELD_WIDTH-1:0] child_mirror [TABLE_DEPTH];
    int                     fill;
    logic [COUNT_WIDTH-1:0] threshold_shadow;

    table_reply_t expected_replies [$];
    script_row_t  script [$];
    int           commands_sent;
    int           replies_checked;
    int           mismatches;
    bit           sender_calm;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // overall limit on the run
    initial
    begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // apply one command to the shadow table and return the reply it should give
    function automatic table_reply_t table_apply(command_t cmd, logic [KEY_WIDTH-1:0] k,
                                                 logic [FIELD_WIDTH-1:0] v);
        table_reply_t r;
        int           hit;
        int           slot;
        int           i;
        r.status      = ST_OK;
        r.found_child = '0;
        hit = fill;
        for (i = fill - 1; i >= 0; i--)
            if (key_mirror[i] == k)
                hit = i;
        case (cmd)
            CMD_INSERT:
            begin
                if (fill >= TABLE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    // new pair lands after any equal keys
                    slot = 0;
                    while (slot < fill && k >= key_mirror[slot])
                        slot++;
                    for (i = fill; i > slot; i--)
                    begin
                        key_mirror[i]   = key_mirror[i-1];
                        child_mirror[i] = child_mirror[i-1];
                    end
                    key_mirror[slot]   = k;
                    child_mirror[slot] = v;
                    fill++;
                end
            end
            CMD_LOOKUP:
            begin
                if (hit < fill)
                    r.found_child = child_mirror[hit];
                else
                    r.status = ST_MISSING;
            end
            CMD_REMOVE:
            begin
                // threshold check wins even over an absent key
                if (fill == threshold_shadow)
                    r.status = ST_SHRINK;
                else if (hit < fill)
                begin
                    for (i = hit; i + 1 < fill; i++)
                    begin
                        key_mirror[i]   = key_mirror[i+1];
                        child_mirror[i] = child_mirror[i+1];
                    end
                    fill--;
                end
                else
                    r.status = ST_MISSING;
            end
            default:
            begin
                if (hit < fill)
                    child_mirror[hit] = v;
                else
                    r.status = ST_MISSING;
            end
        endcase
        r.entries_now = COUNT_WIDTH'(fill);
        return r;
    endfunction

    function automatic int draw_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic void add_step(row_kind_t kind, command_t cmd, logic [KEY_WIDTH-1:0] k,
                                     logic [FIELD_WIDTH-1:0] v, int reps, bit typed,
                                     status_t st, logic [FIELD_WIDTH-1:0] fc,
                                     logic [COUNT_WIDTH-1:0] n);
        script_row_t row;
        row.kind             = kind;
        row.command          = cmd;
        row.key              = k;
        row.child_value      = v;
        row.reps             = 5'(reps);
        row.typed            = typed;
        row.want.status      = st;
        row.want.found_child = fc;
        row.want.entries_now = n;
        script.push_back(row);
    endfunction

    // present one command beat, wait for it to be taken, then record its reply
    task automatic offer_command(command_t cmd, logic [KEY_WIDTH-1:0] k,
                                 logic [FIELD_WIDTH-1:0] v, bit typed, table_reply_t want);
        int           gap;
        table_reply_t reply;
        gap = sender_calm ? 0 : draw_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.command     <= cmd;
        req_ch.key         <= k;
        req_ch.child_value <= v;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        reply = table_apply(cmd, k, v);
        expected_replies.push_back(typed ? want : reply);
        commands_sent++;
    endtask

    // stop offering and wait until every reply has come back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (replies_checked != commands_sent);
    endtask

    task automatic write_threshold(logic [COUNT_WIDTH-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        threshold_shadow = value;
    endtask

    // response side: random stalls, quiet stretches and one long hold-off
    initial
    begin
        int  stall_left;
        int  quiet_left;
        bit  pressure_done;
        stall_left    = 0;
        quiet_left    = 0;
        pressure_done = 1'b0;
        rsp_ch.ready  = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left == 0)
            begin
                if (!pressure_done && commands_sent >= 400)
                begin
                    pressure_done = 1'b1;
                    stall_left    = 80;
                end
                else if (quiet_left > 0)
                    quiet_left--;
                else if ($urandom_range(0, 99) < 2)
                    quiet_left = $urandom_range(30, 120);
                else
                    stall_left = draw_gap();
            end
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // compare every response beat with the oldest expected reply
    always @(posedge clk)
    begin
        table_reply_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected reply status %0d child %h entries %0d", $time,
                         rsp_ch.status, rsp_ch.found_child, rsp_ch.entries_now);
                mismatches++;
            end
            else
            begin
                want = expected_replies.pop_front();
                replies_checked++;
                if (rsp_ch.status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d", $time,
                             want.status, rsp_ch.status);
                    mismatches++;
                end
                if (rsp_ch.found_child !== want.found_child)
                begin
                    $display("%0t: found_child expected %h got %h", $time,
                             want.found_child, rsp_ch.found_child);
                    mismatches++;
                end
                if (rsp_ch.entries_now !== want.entries_now)
                begin
                    $display("%0t: entries_now expected %0d got %0d", $time,
                             want.entries_now, rsp_ch.entries_now);
                    mismatches++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        script_row_t            row;
        table_reply_t           none;
        int                     i;
        int                     ph;
        int                     n;
        int                     mood_left;
        bit                     filling;
        int                     pick;
        command_t               cmd;
        logic [KEY_WIDTH-1:0]   k;
        logic [FIELD_WIDTH-1:0] v;
        logic [COUNT_WIDTH-1:0] th;
        logic [COUNT_WIDTH-1:0] phase_thresholds [5];

        rst_n              = 1'b0;
        cfg_wen            = 1'b0;
        cfg_wdata          = '0;
        req_ch.valid       = 1'b0;
        req_ch.command     = CMD_INSERT;
        req_ch.key         = '0;
        req_ch.child_value = '0;
        fill               = 0;
        threshold_shadow   = SHRINK_RESET;
        commands_sent      = 0;
        replies_checked    = 0;
        mismatches         = 0;
        sender_calm        = 1'b0;
        none               = '0;
        phase_thresholds   = '{5'd0, 5'd16, 5'd2, 5'd31, 5'd4};
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            key_mirror[i]   = '0;
            child_mirror[i] = '0;
        end

        // directed table: kind, command, key, child, reps, typed, status, child, entries
        add_step(ROW_CMD, CMD_LOOKUP, 8'h00, '0, 1, 1, ST_MISSING, '0, 5'd0);
        add_step(ROW_CMD, CMD_REMOVE, 8'h55, '0, 1, 1, ST_MISSING, '0, 5'd0);
        add_step(ROW_CMD, CMD_CHANGE, 8'hff, 64'h1234, 1, 1, ST_MISSING, '0, 5'd0);
        add_step(ROW_CMD, CMD_INSERT, 8'hff, '1, 1, 1, ST_OK, '0, 5'd1);
        add_step(ROW_CMD, CMD_INSERT, 8'h00, '0, 1, 1, ST_OK, '0, 5'd2);
        add_step(ROW_CMD, CMD_LOOKUP, 8'hff, '0, 1, 1, ST_OK, '1, 5'd2);
        add_step(ROW_CMD, CMD_LOOKUP, 8'h00, '1, 1, 1, ST_OK, '0, 5'd2);
        add_step(ROW_CMD, CMD_INSERT, 8'h80, 64'h0123_4567_89ab_cdef, 1, 0, ST_OK, '0, 0);
        add_step(ROW_CMD, CMD_INSERT, 8'h80, 64'hfedc_ba98_7654_3210, 1, 0, ST_OK, '0, 0);
        add_step(ROW_CMD, CMD_LOOKUP, 8'h80, '0, 1, 0, ST_OK, '0, 0);
        add_step(ROW_CMD, CMD_REMOVE, 8'h80, '0, 1, 1, ST_SHRINK, '0, 5'd4);
        add_step(ROW_CMD, CMD_REMOVE, 8'h12, '0, 1, 1, ST_SHRINK, '0, 5'd4);
        add_step(ROW_CMD, CMD_INSERT, 8'h40, 64'h5555_5555_5555_5555, 1, 0, ST_OK, '0, 0);
        add_step(ROW_CMD, CMD_REMOVE, 8'h80, '0, 1, 0, ST_OK, '0, 0);
        add_step(ROW_CMD, CMD_LOOKUP, 8'h80, '0, 1, 0, ST_OK, '0, 0);
        add_step(ROW_CMD, CMD_CHANGE, 8'h80, 64'haaaa_aaaa_aaaa_aaaa, 1, 0, ST_OK, '0, 0);
        add_step(ROW_CMD, CMD_LOOKUP, 8'h80, '0, 1, 0, ST_OK, '0, 0);
        add_step(ROW_CMD, CMD_INSERT, 8'h20, 64'h1000, 12, 0, ST_OK, '0, 0);
        add_step(ROW_CMD, CMD_INSERT, 8'h33, 64'h77, 1, 1, ST_FULL, '0, 5'd16);
        add_step(ROW_CMD, CMD_LOOKUP, 8'h7f, '0, 1, 1, ST_MISSING, '0, 5'd16);
        add_step(ROW_CFG, CMD_INSERT, 8'd16, '0, 1, 0, ST_OK, '0, 0);
        add_step(ROW_CMD, CMD_REMOVE, 8'h00, '0, 1, 1, ST_SHRINK, '0, 5'd16);
        add_step(ROW_CFG, CMD_INSERT, 8'd31, '0, 1, 0, ST_OK, '0, 0);
        add_step(ROW_CMD, CMD_REMOVE, 8'h20, '0, 13, 0, ST_OK, '0, 0);
        add_step(ROW_CMD, CMD_REMOVE, 8'h40, '0, 1, 0, ST_OK, '0, 0);

        // reset
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (script[r])
        begin
            row = script[r];
            if (row.kind == ROW_CFG)
            begin
                wait_drained();
                write_threshold(row.key[COUNT_WIDTH-1:0]);
            end
            else
                for (i = 0; i < row.reps; i++)
                    offer_command(row.command, row.key + KEY_WIDTH'(i),
                                  row.child_value + FIELD_WIDTH'(i),
                                  row.typed, row.want);
        end

        // random phases, each under its own threshold
        filling   = 1'b1;
        mood_left = 0;
        for (ph = 0; ph < 7; ph++)
        begin
            th = (ph < 5) ? phase_thresholds[ph] : COUNT_WIDTH'($urandom_range(0, 31));
            wait_drained();
            write_threshold(th);
            for (n = 0; n < 200; n++)
            begin
                if (n % 50 == 0)
                    sender_calm = ($urandom_range(0, 3) == 0);
                // alternate between filling and draining the table
                if (mood_left == 0)
                begin
                    filling   = ~filling;
                    mood_left = $urandom_range(20, 60);
                end
                mood_left--;
                pick = $urandom_range(0, 99);
                if (pick < (filling ? 50 : 20))
                    cmd = CMD_INSERT;
                else if (pick < 70)
                    cmd = CMD_REMOVE;
                else if (pick < 85)
                    cmd = CMD_LOOKUP;
                else
                    cmd = CMD_CHANGE;
                // keys mostly hit stored entries or a small crowded range
                pick = $urandom_range(0, 99);
                if (pick < 50 && fill > 0)
                    k = key_mirror[$urandom_range(0, fill - 1)];
                else if (pick < 80)
                    k = KEY_WIDTH'($urandom_range(0, 7));
                else
                    k = KEY_WIDTH'($urandom_range(0, 255));
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    v = '0;
                else if (pick == 1)
                    v = '1;
                else
                    v = {$urandom, $urandom};
                offer_command(cmd, k, v, 1'b0, none);
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
